/* rtl/core/life_generation_stencil_defines.svh */
// ----------------------------------------------------------------------------
// life_generation_stencil_defines.svh
// Assertion macros for the Life generation stencil; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STENCIL_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent checked in the same cycle as the antecedent.
`define LGS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("life stencil assertion failed");

// Consequent checked in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("life stencil assertion failed");

`else

`define LGS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/core/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, codes and types of the Life generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Line store depth, i.e. the widest grid supported.
    localparam int MAX_COLS   = 128;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int COLS_W     = $clog2(MAX_COLS + 1);
    localparam int WARM_W     = $clog2(MAX_COLS + 2);
    localparam int ROW_W      = 12;
    localparam int CFG_COLS_W = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0]  REG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  REG_GRID_COLS = CFG_IDX_W'(1);
    localparam logic [ROW_W-1:0]      RST_GRID_ROWS = ROW_W'(128);
    localparam logic [CFG_COLS_W-1:0] RST_GRID_COLS = CFG_COLS_W'(128);

    // B3/S23
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    // 3x3 window, bit j*3+b: j = column (0 left), b = row (0 top)
    typedef logic [8:0] t_window;

    // Stored column pair: [1] one row up, [0] two rows up
    typedef logic [1:0] t_col_pair;

    typedef struct packed {
        logic at_top;
        logic at_bottom;
        logic at_left;
        logic at_right;
    } t_border;

endpackage

/* rtl/core/lgs_cell_if.sv */
// ----------------------------------------------------------------------------
// lgs_cell_if
// Input stream: one grid cell or flush beat per transfer.
// ----------------------------------------------------------------------------
interface lgs_cell_if;
    logic valid;
    logic ready;
    logic operation;
    logic cell_alive;

    modport source (output valid, output operation, output cell_alive, input ready);
    modport sink   (input valid, input operation, input cell_alive, output ready);
endinterface

/* rtl/core/lgs_result_if.sv */
// ----------------------------------------------------------------------------
// lgs_result_if
// Output stream: next-generation value of one cell with its position.
// ----------------------------------------------------------------------------
interface lgs_result_if;
    logic                      valid;
    logic                      ready;
    logic                      next_alive;
    logic [lgs_pkg::ROW_W-1:0] cell_row;
    logic [lgs_pkg::COL_W-1:0] cell_col;
    logic                      last_of_frame;

    modport source (
        output valid, output next_alive, output cell_row, output cell_col,
        output last_of_frame, input ready
    );
    modport sink (
        input valid, input next_alive, input cell_row, input cell_col,
        input last_of_frame, output ready
    );
endinterface

/* rtl/core/life_generation_stencil.sv */
// ----------------------------------------------------------------------------
// life_generation_stencil
// One generation of Life (B3/S23) on a bounded grid, streamed in raster order.
// ----------------------------------------------------------------------------
// The current generation enters one cell per beat in raster order, grid_rows
// by grid_cols (zero acts as one, columns clamp to 128). Off-grid neighbors
// are dead, no wrap-around. The result for cell (r,c) leaves once the beat of
// cell (r+1,c+1) is taken, i.e. grid_cols+1 beats after cell (r,c); after the
// last cell send grid_cols+1 flush beats (operation=1) to drain the frame.
// Flush beats before the last cell and after the frame is done are taken and
// dropped; a cell beat while draining counts as a flush. One beat is taken
// every clock: the 2-bit line store RAM is read one beat ahead, so the only
// loop is the 3x3 window shift plus the masked count, and a result lands in the
// output register in the cycle after its beat. The input stalls only while
// that register holds a result the sink has not taken. No clearing pass after
// reset. Writing either size register restarts the frame; write only while
// the block is idle.
// ----------------------------------------------------------------------------
`include "life_generation_stencil_defines.svh"

module life_generation_stencil (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    lgs_cell_if.sink                       i_cell,
    lgs_result_if.source                   o_result
);
    import lgs_pkg::*;

    // Size registers
    logic [ROW_W-1:0]      r_grid_rows;
    logic [CFG_COLS_W-1:0] r_grid_cols;

    // Effective sizes
    logic [ROW_W-1:0]  w_rows;
    logic [ROW_W-1:0]  w_last_row;
    logic [COLS_W-1:0] w_cols;
    logic [COLS_W-1:0] w_cols_m1;
    logic [COL_W-1:0]  w_last_col;
    logic [WARM_W-1:0] w_cols_p1;

    // Scan state: input column/row, drain flag, warm-up count, window,
    // output column/row
    logic [COL_W-1:0]  r_icol,    n_icol;
    logic [ROW_W-1:0]  r_irow,    n_irow;
    logic              r_in_done, n_in_done;
    logic [WARM_W-1:0] r_warm,    n_warm;
    t_window           r_window,  n_window;
    logic [COL_W-1:0]  r_ocol,    n_ocol;
    logic [ROW_W-1:0]  r_orow,    n_orow;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic             r_out_alive;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;
    logic             r_out_last;

    logic       w_in_take;
    logic       w_process;
    logic       w_value;
    logic       w_icol_last;
    logic       w_warm_full;
    logic       w_emit;
    logic       w_restart;
    logic [2:0] w_column;
    logic [COL_W-1:0] w_rd_addr;
    t_col_pair  w_pair;
    t_border    w_border;
    t_window    w_shift_window;
    logic       w_alive;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= RST_GRID_ROWS;
            r_grid_cols <= RST_GRID_COLS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_GRID_ROWS: r_grid_rows <= i_cfg_wdata[ROW_W-1:0];
                REG_GRID_COLS: r_grid_cols <= i_cfg_wdata[CFG_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_rows     = (r_grid_rows == '0) ? ROW_W'(1) : r_grid_rows;
    assign w_last_row = w_rows - ROW_W'(1);

    always_comb begin
        if (r_grid_cols == '0) begin
            w_cols = COLS_W'(1);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            w_cols = COLS_W'(MAX_COLS);
        end else begin
            w_cols = COLS_W'(r_grid_cols);
        end
    end

    assign w_cols_m1  = w_cols - COLS_W'(1);
    assign w_last_col = w_cols_m1[COL_W-1:0];
    assign w_cols_p1  = WARM_W'(w_cols) + WARM_W'(1);

    // ---- beat handling ----
    // Output register frees as the sink takes its result.
    assign i_cell.ready = !r_out_valid || o_result.ready;
    assign w_in_take    = i_cell.valid && i_cell.ready;

    // Before the last cell only cell beats count; afterwards every beat
    // pushes a dead cell through.
    assign w_process = w_in_take && (r_in_done || (i_cell.operation == OP_CELL));
    assign w_value   = r_in_done ? 1'b0 : i_cell.cell_alive;

    assign w_icol_last = (r_icol == w_last_col);
    // Window holds cell (r,c) centered once cols+1 beats are in.
    assign w_warm_full = (r_warm == w_cols_p1);
    assign w_emit      = w_process && w_warm_full;

    assign w_border.at_top    = (r_orow == '0);
    assign w_border.at_bottom = (r_orow == w_last_row);
    assign w_border.at_left   = (r_ocol == '0);
    assign w_border.at_right  = (r_ocol == w_last_col);

    assign w_restart = i_cfg_wr_en || (w_emit && w_border.at_bottom && w_border.at_right);

    // New column: two rows up, one row up, current
    assign w_column = {w_value, w_pair[1], w_pair[0]};

    // Window after the shift, ignoring the frame restart clear.
    assign w_shift_window = {w_column, r_window[8:3]};

    always_comb begin
        n_icol    = r_icol;
        n_irow    = r_irow;
        n_in_done = r_in_done;
        n_warm    = r_warm;
        n_window  = r_window;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        if (w_process) begin
            n_window = w_shift_window;
            n_icol   = w_icol_last ? '0 : r_icol + COL_W'(1);
            if (w_icol_last && !r_in_done) begin
                if (r_irow == w_last_row) begin
                    n_in_done = 1'b1;
                end else begin
                    n_irow = r_irow + ROW_W'(1);
                end
            end
            if (!w_warm_full) begin
                n_warm = r_warm + WARM_W'(1);
            end
            if (w_emit) begin
                n_ocol = w_border.at_right ? '0 : r_ocol + COL_W'(1);
                if (w_border.at_right) begin
                    n_orow = r_orow + ROW_W'(1);
                end
            end
        end
        if (w_restart) begin
            n_icol    = '0;
            n_irow    = '0;
            n_in_done = 1'b0;
            n_warm    = '0;
            n_window  = '0;
            n_ocol    = '0;
            n_orow    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icol    <= '0;
            r_irow    <= '0;
            r_in_done <= 1'b0;
            r_warm    <= '0;
            r_window  <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
        end else begin
            r_icol    <= n_icol;
            r_irow    <= n_irow;
            r_in_done <= n_in_done;
            r_warm    <= n_warm;
            r_window  <= n_window;
            r_ocol    <= n_ocol;
            r_orow    <= n_orow;
        end
    end

    // ---- line stores ----
    // Read at the column of the next beat so the data is ready when it lands.
    assign w_rd_addr = i_rst_n ? n_icol : '0;

    lgs_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_process),
        .i_wr_addr (r_icol),
        .i_wr_data ({w_value, w_pair[1]}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_pair)
    );

    // ---- rule on the shifted window ----
    lgs_rule u_rule (
        .i_window (w_shift_window),
        .i_border (w_border),
        .o_alive  (w_alive)
    );

    // ---- output register ----
    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_alive <= w_alive;
            r_out_row   <= r_orow;
            r_out_col   <= r_ocol;
            r_out_last  <= w_border.at_bottom && w_border.at_right;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.next_alive    = r_out_alive;
    assign o_result.cell_row      = r_out_row;
    assign o_result.cell_col      = r_out_col;
    assign o_result.last_of_frame = r_out_last;

    // ---- assertions ----
    // Last cell of a frame leaves the scan state cleared.
    `LGS_ASSERT_NEXT(a_frame_wraps, i_clk, i_rst_n, w_emit && w_border.at_bottom && w_border.at_right, r_orow == '0 && r_ocol == '0 && r_warm == '0 && !r_in_done)
    // Output never runs ahead of the input rows.
    `LGS_ASSERT_SAME(a_out_behind_in, i_clk, i_rst_n, !r_in_done, r_orow <= r_irow)
    // A result appears only after a beat was taken.
    `LGS_ASSERT_SAME(a_result_from_beat, i_clk, i_rst_n, $rose(o_result.valid), $past(w_in_take))

endmodule

/* rtl/core/lgs_ram.sv */
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/core/lgs_line_buf.sv */
// ----------------------------------------------------------------------------
// lgs_line_buf
// Two line stores in one RAM, read one beat ahead, with write bypass.
// ----------------------------------------------------------------------------
module lgs_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [lgs_pkg::COL_W-1:0] i_wr_addr,
    input  lgs_pkg::t_col_pair        i_wr_data,
    input  logic [lgs_pkg::COL_W-1:0] i_rd_addr,
    output lgs_pkg::t_col_pair        o_rd_data
);
    import lgs_pkg::*;

    t_col_pair w_ram_data;
    logic      r_byp;
    logic      n_byp;
    t_col_pair r_byp_data;

    lgs_ram #(
        .WIDTH ($bits(t_col_pair)),
        .DEPTH (MAX_COLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_ram_data)
    );

    // Same-cycle read of the address being written (one-column grid)
    assign n_byp = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_wr_data;
    end

    assign o_rd_data = r_byp ? r_byp_data : w_ram_data;
endmodule

/* rtl/core/lgs_rule.sv */
// ----------------------------------------------------------------------------
// lgs_rule
// Masked neighbor count and B3/S23 decision for the window center.
// ----------------------------------------------------------------------------
module lgs_rule (
    input  lgs_pkg::t_window i_window,
    input  lgs_pkg::t_border i_border,
    output logic             o_alive
);
    import lgs_pkg::*;

    logic [3:0] w_count;

    always_comb begin
        logic v_use;
        w_count = '0;
        for (int j = 0; j < 3; j++) begin
            for (int b = 0; b < 3; b++) begin
                v_use = !(j == 1 && b == 1)
                     && !(j == 0 && i_border.at_left)
                     && !(j == 2 && i_border.at_right)
                     && !(b == 0 && i_border.at_top)
                     && !(b == 2 && i_border.at_bottom);
                if (v_use) begin
                    w_count = w_count + 4'(i_window[j*3 + b]);
                end
            end
        end
    end

    assign o_alive = (w_count == 4'(BIRTH_COUNT))
                  || (i_window[4] && (w_count == 4'(SURVIVE_COUNT)));
endmodule
